FILE: hdl/tbsr_pkg.sv
// shared types and constants of the throttle and brake speed regulator
`timescale 1ns / 1ps
package tbsr_pkg;

	// field and register widths
	localparam int unsigned SPEED_W    = 32;
	localparam int unsigned MS_W       = 16;
	localparam int unsigned REG_W      = 31;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned MODE_W     = 2;
	localparam int unsigned Q_FRAC     = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_GAIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_GAIN      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_THROTTLE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_BRAKE       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_RATE       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_SPEED_BAND = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_GEAR_COAST_BAND = 3'd6;

	// register reset values, Q16.16
	localparam logic [REG_W-1:0] RST_GAIN       = 31'd65536;
	localparam logic [REG_W-1:0] RST_MAX        = 31'd65536;
	localparam logic [REG_W-1:0] RST_RAMP_RATE  = 31'd65536;
	localparam logic [REG_W-1:0] RST_STOP_BAND  = 31'd32768;
	localparam logic [REG_W-1:0] RST_COAST_BAND = 31'd65536;

	// drive modes
	localparam logic [MODE_W-1:0] MODE_STOP  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ACCEL = 2'd1;
	localparam logic [MODE_W-1:0] MODE_COAST = 2'd2;
	localparam logic [MODE_W-1:0] MODE_BRAKE = 2'd3;

	// 0.001 in Q16.16, rounded
	localparam logic [REG_W-1:0] SMALL_BRAKE = 31'd66;

	// arithmetic units
	localparam int unsigned PROD_W      = 64;
	localparam int unsigned MPLIER_W    = 32;
	localparam int unsigned MUL_DIGIT_W = 4;
	localparam int unsigned DIVISOR     = 1000;
	localparam int unsigned DIV_DIGIT_W = 2;
	localparam int unsigned DIV_DIGITS  = PROD_W / DIV_DIGIT_W;
	localparam int unsigned REM_W       = 10;

	typedef struct packed {
		logic signed [SPEED_W-1:0] target_speed;
		logic signed [SPEED_W-1:0] measured_speed;
		logic        [MS_W-1:0]    elapsed_ms;
		logic                      arrived;
	} req_t;

	typedef struct packed {
		logic signed [SPEED_W-1:0] throttle_level;
		logic signed [SPEED_W-1:0] brake_level;
		logic signed [SPEED_W-1:0] ramped_speed;
		logic        [MODE_W-1:0]  drive_mode;
	} rsp_t;

	typedef struct packed {
		logic                start;
		logic [PROD_W-1:0]   mcand;
		logic [MPLIER_W-1:0] mplier;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic              busy;
		logic [PROD_W-1:0] prod;
	} mul_rsp_t;

	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] dvd;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic              busy;
		logic [PROD_W-1:0] quo;
	} div_rsp_t;

endpackage

FILE: hdl/tbsr_mul.sv
// digit-serial shift-add multiplier, one multiplier digit per cycle
`timescale 1ns / 1ps
module tbsr_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  tbsr_pkg::mul_req_t  req,
	output tbsr_pkg::mul_rsp_t  rsp
);
	localparam int unsigned DigW = tbsr_pkg::MUL_DIGIT_W;
	localparam int unsigned ProdW = tbsr_pkg::PROD_W;
	localparam int unsigned PpW = ProdW + DigW;

	logic                            busy_q;
	logic [ProdW-1:0]                acc_q;
	logic [ProdW-1:0]                mcand_q;
	logic [tbsr_pkg::MPLIER_W-1:0]   mplier_q;
	logic [PpW-1:0]                  pp;
	logic                            done;

	// multiplicand times the low digit of the remaining multiplier
	assign pp = PpW'(mcand_q) * PpW'(mplier_q[DigW-1:0]);

	// finished once every nonzero digit has been consumed
	assign done = busy_q && (mplier_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q    <= '0;
			mcand_q  <= req.mcand;
			mplier_q <= req.mplier;
		end else if (busy_q && (mplier_q != '0)) begin
			acc_q    <= acc_q + pp[ProdW-1:0];
			mcand_q  <= mcand_q << DigW;
			mplier_q <= mplier_q >> DigW;
		end
	end

	assign rsp.done = done;
	assign rsp.busy = busy_q;
	assign rsp.prod = acc_q;

endmodule

FILE: hdl/tbsr_div.sv
// radix-4 restoring divider by the constant 1000, one quotient digit per cycle
`timescale 1ns / 1ps
module tbsr_div (
	input  logic                clk,
	input  logic                arst_n,
	input  tbsr_pkg::div_req_t  req,
	output tbsr_pkg::div_rsp_t  rsp
);
	localparam int unsigned ProdW = tbsr_pkg::PROD_W;
	localparam int unsigned DigW = tbsr_pkg::DIV_DIGIT_W;
	localparam int unsigned RemW = tbsr_pkg::REM_W;
	localparam int unsigned TW = RemW + DigW;
	localparam int unsigned CntW = $clog2(tbsr_pkg::DIV_DIGITS);
	localparam logic [TW-1:0] D1 = TW'(tbsr_pkg::DIVISOR);
	localparam logic [TW-1:0] D2 = TW'(2 * tbsr_pkg::DIVISOR);
	localparam logic [TW-1:0] D3 = TW'(3 * tbsr_pkg::DIVISOR);

	logic              busy_q;
	logic              done_q;
	logic [CntW-1:0]   cnt_q;
	logic [RemW-1:0]   rem_q;
	logic [ProdW-1:0]  dvd_q;
	logic [TW-1:0]     t;
	logic [TW-1:0]     t_rem;
	logic [DigW-1:0]   qd;

	// partial remainder with the next dividend digit shifted in
	assign t = {rem_q, dvd_q[ProdW-1 -: DigW]};

	always_comb begin
		priority if (t >= D3) begin
			qd    = 2'd3;
			t_rem = t - D3;
		end else if (t >= D2) begin
			qd    = 2'd2;
			t_rem = t - D2;
		end else if (t >= D1) begin
			qd    = 2'd1;
			t_rem = t - D1;
		end else begin
			qd    = 2'd0;
			t_rem = t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '1;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// quotient digits enter at the bottom as dividend digits leave the top
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dvd;
		end else if (busy_q) begin
			rem_q <= t_rem[RemW-1:0];
			dvd_q <= {dvd_q[ProdW-DigW-1:0], qd};
		end
	end

	assign rsp.done = done_q;
	assign rsp.busy = busy_q;
	assign rsp.quo  = dvd_q;

endmodule

FILE: hdl/throttle_brake_speed_regulator.sv
// top level: control sequencer, registers and result stage of the speed regulator
`timescale 1ns / 1ps
//
// channel  | dir | handshake              | beat
// ---------+-----+------------------------+---------------------------------------------
// req      | in  | req_valid / req_ready  | target, measured speed, elapsed ms, dest flag
// rsp      | out | rsp_valid / rsp_ready  | throttle, brake, ramped speed, drive mode
// cfg      | in  | cfg_valid / cfg_ready  | register index and write data
//
// stop and coast ticks take one multiply and one 32-digit divide by 1000; accelerate and brake
// ticks add two more multiplies and a second divide, the shift-add multiplies sharing one unit
// one tick is worked at a time; req_ready is high only while the sequencer is idle
// the result register lets the next tick be accepted while a result beat still waits
// a stalled rsp holds the sequencer in its final state until the result register frees
// reset clears the ramp and brake state and loads the register defaults; cfg is always ready
//
module throttle_brake_speed_regulator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  tbsr_pkg::req_t                      req,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output tbsr_pkg::rsp_t                      rsp,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tbsr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tbsr_pkg::CFG_DATA_W-1:0]     cfg_data
);
	localparam int unsigned SpW = tbsr_pkg::SPEED_W;
	localparam int unsigned RegW = tbsr_pkg::REG_W;
	localparam int unsigned ProdW = tbsr_pkg::PROD_W;

	typedef enum logic [8:0] {
		ST_IDLE     = 9'b000000001,
		ST_MUL_STEP = 9'b000000010,
		ST_DIV_STEP = 9'b000000100,
		ST_RAMP     = 9'b000001000,
		ST_MODE     = 9'b000010000,
		ST_MUL_GAIN = 9'b000100000,
		ST_MUL_TIME = 9'b001000000,
		ST_DIV_PROP = 9'b010000000,
		ST_FIN      = 9'b100000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [RegW-1:0] throttle_gain_q;
	logic [RegW-1:0] brake_gain_q;
	logic [RegW-1:0] max_throttle_q;
	logic [RegW-1:0] max_brake_q;
	logic [RegW-1:0] ramp_rate_q;
	logic [RegW-1:0] stop_band_q;
	logic [RegW-1:0] coast_band_q;

	// tick in flight and kept state
	tbsr_pkg::req_t                 req_q;
	logic [SpW-1:0]                 ramp_q;
	logic [SpW-1:0]                 brake_q;
	logic [tbsr_pkg::MODE_W-1:0]    mode_q;
	logic                           neg_q;

	// result stage
	tbsr_pkg::rsp_t rsp_q;
	logic           rsp_valid_q;
	logic           out_load;

	// shared arithmetic units
	tbsr_pkg::mul_req_t mul_req;
	tbsr_pkg::mul_rsp_t mul_rsp;
	tbsr_pkg::div_req_t div_req;
	tbsr_pkg::div_rsp_t div_rsp;

	// ramp update
	logic [SpW:0]     rdiff;
	logic [SpW:0]     rdiff_neg;
	logic [SpW:0]     rmag;
	logic [ProdW-1:0] step;
	logic             step_past;
	logic [SpW-1:0]   ramp_nxt;

	// mode choice
	logic [SpW:0]                ramp33;
	logic [SpW:0]                meas33;
	logic [SpW:0]                tgt33;
	logic [SpW:0]                over;
	logic [SpW:0]                under;
	logic [SpW:0]                berr;
	logic [SpW:0]                berr_neg;
	logic                        accel_c;
	logic                        stop_c;
	logic                        coast_c;
	logic [tbsr_pkg::MODE_W-1:0] mode_nxt;
	logic                        need_p;
	logic [SpW-1:0]              err_mag;
	logic [RegW-1:0]             gain_sel;

	// final outputs
	logic [ProdW-1:0] p;
	logic [SpW-1:0]   thr_nxt;
	logic [SpW-1:0]   brk_nxt;
	logic [SpW-1:0]   small_brk;
	logic [SpW-1:0]   stop_brk;
	logic [SpW-1:0]   neg_brk;

	tbsr_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	tbsr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// handshakes
	assign req_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign out_load  = (state_q == ST_FIN) && (!rsp_valid_q || rsp_ready);

	// configuration writes, out-of-range indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			throttle_gain_q <= tbsr_pkg::RST_GAIN;
			brake_gain_q    <= tbsr_pkg::RST_GAIN;
			max_throttle_q  <= tbsr_pkg::RST_MAX;
			max_brake_q     <= tbsr_pkg::RST_MAX;
			ramp_rate_q     <= tbsr_pkg::RST_RAMP_RATE;
			stop_band_q     <= tbsr_pkg::RST_STOP_BAND;
			coast_band_q    <= tbsr_pkg::RST_COAST_BAND;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tbsr_pkg::CFG_THROTTLE_GAIN:   throttle_gain_q <= cfg_data[RegW-1:0];
				tbsr_pkg::CFG_BRAKE_GAIN:      brake_gain_q    <= cfg_data[RegW-1:0];
				tbsr_pkg::CFG_MAX_THROTTLE:    max_throttle_q  <= cfg_data[RegW-1:0];
				tbsr_pkg::CFG_MAX_BRAKE:       max_brake_q     <= cfg_data[RegW-1:0];
				tbsr_pkg::CFG_RAMP_RATE:       ramp_rate_q     <= cfg_data[RegW-1:0];
				tbsr_pkg::CFG_STOP_SPEED_BAND: stop_band_q     <= cfg_data[RegW-1:0];
				tbsr_pkg::CFG_GEAR_COAST_BAND: coast_band_q    <= cfg_data[RegW-1:0];
				default: ;
			endcase
		end
	end

	// ramp moves toward the target by at most step, landing on it when closer than step
	assign step      = div_rsp.quo;
	assign rdiff     = {ramp_q[SpW-1], ramp_q} - {req_q.target_speed[SpW-1], req_q.target_speed};
	assign rdiff_neg = '0 - rdiff;
	assign rmag      = rdiff[SpW] ? rdiff_neg : rdiff;
	assign step_past = (step[ProdW-1:SpW+1] != '0) || (rmag < step[SpW:0]);

	always_comb begin
		priority if (step_past) begin
			ramp_nxt = req_q.target_speed;
		end else if (rdiff[SpW]) begin
			ramp_nxt = ramp_q + step[SpW-1:0];
		end else if (rdiff != '0) begin
			ramp_nxt = ramp_q - step[SpW-1:0];
		end else begin
			ramp_nxt = ramp_q;
		end
	end

	// mode choice on the updated ramp
	assign ramp33   = {ramp_q[SpW-1], ramp_q};
	assign meas33   = {req_q.measured_speed[SpW-1], req_q.measured_speed};
	assign tgt33    = {req_q.target_speed[SpW-1], req_q.target_speed};
	assign over     = meas33 - ramp33;
	assign under    = ramp33 - meas33;
	assign berr     = meas33 - tgt33;
	assign berr_neg = '0 - berr;

	assign accel_c = !under[SpW];
	assign stop_c  = (ramp_q[SpW-1] || (ramp_q == '0))
		&& ($signed(meas33) < $signed({2'b00, stop_band_q}));
	assign coast_c = ($signed(over) < $signed({2'b00, coast_band_q}))
		&& !req_q.target_speed[SpW-1] && (req_q.target_speed != '0);

	always_comb begin
		priority if (req_q.arrived) begin
			mode_nxt = tbsr_pkg::MODE_STOP;
		end else if (accel_c) begin
			mode_nxt = tbsr_pkg::MODE_ACCEL;
		end else if (stop_c) begin
			mode_nxt = tbsr_pkg::MODE_STOP;
		end else if (coast_c) begin
			mode_nxt = tbsr_pkg::MODE_COAST;
		end else begin
			mode_nxt = tbsr_pkg::MODE_BRAKE;
		end
	end

	assign need_p   = (mode_nxt == tbsr_pkg::MODE_ACCEL) || (mode_nxt == tbsr_pkg::MODE_BRAKE);
	assign err_mag  = (mode_nxt == tbsr_pkg::MODE_ACCEL) ? under[SpW-1:0]
		: (berr[SpW] ? berr_neg[SpW-1:0] : berr[SpW-1:0]);
	assign gain_sel = (mode_nxt == tbsr_pkg::MODE_ACCEL) ? throttle_gain_q : brake_gain_q;

	// unit requests: step = ms * rate / 1000, then p = (|err| * gain >> 16) * ms / 1000
	always_comb begin
		mul_req = '0;
		div_req = '0;
		unique case (state_q)
			ST_IDLE: begin
				mul_req.start  = req_valid;
				mul_req.mcand  = ProdW'(ramp_rate_q);
				mul_req.mplier = tbsr_pkg::MPLIER_W'(req.elapsed_ms);
			end
			ST_MUL_STEP: begin
				div_req.start = mul_rsp.done;
				div_req.dvd   = mul_rsp.prod;
			end
			ST_MODE: begin
				mul_req.start  = need_p;
				mul_req.mcand  = ProdW'(gain_sel);
				mul_req.mplier = err_mag;
			end
			ST_MUL_GAIN: begin
				mul_req.start  = mul_rsp.done;
				mul_req.mcand  = ProdW'(mul_rsp.prod[ProdW-1:tbsr_pkg::Q_FRAC]);
				mul_req.mplier = tbsr_pkg::MPLIER_W'(req_q.elapsed_ms);
			end
			ST_MUL_TIME: begin
				div_req.start = mul_rsp.done;
				div_req.dvd   = mul_rsp.prod;
			end
			default: ;
		endcase
	end

	// final throttle and brake with the upper clips
	assign p         = div_rsp.quo;
	assign small_brk = (tbsr_pkg::SMALL_BRAKE > max_brake_q) ? {1'b0, max_brake_q}
		: {1'b0, tbsr_pkg::SMALL_BRAKE};
	// kept brake above zero always overshoots the clip
	assign stop_brk  = (!brake_q[SpW-1] && (brake_q != '0)) ? {1'b0, max_brake_q}
		: brake_q + {1'b0, max_brake_q};
	// negative brake saturates at the most negative value
	assign neg_brk   = (p[ProdW-1:SpW-1] != '0) ? {1'b1, {(SpW-1){1'b0}}}
		: ('0 - {1'b0, p[SpW-2:0]});

	always_comb begin
		if ((mode_q == tbsr_pkg::MODE_ACCEL)
			&& ((p[ProdW-1:RegW] != '0) || (p[RegW-1:0] > max_throttle_q))) begin
			thr_nxt = {1'b0, max_throttle_q};
		end else if (mode_q == tbsr_pkg::MODE_ACCEL) begin
			thr_nxt = {1'b0, p[RegW-1:0]};
		end else begin
			thr_nxt = '0;
		end
	end

	always_comb begin
		unique case (mode_q)
			tbsr_pkg::MODE_STOP: begin
				brk_nxt = stop_brk;
			end
			tbsr_pkg::MODE_BRAKE: begin
				if (neg_q) begin
					brk_nxt = neg_brk;
				end else if ((p[ProdW-1:RegW] != '0) || (p[RegW-1:0] > max_brake_q)) begin
					brk_nxt = {1'b0, max_brake_q};
				end else begin
					brk_nxt = {1'b0, p[RegW-1:0]};
				end
			end
			default: begin
				brk_nxt = small_brk;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_MUL_STEP;
					end
				end
				ST_MUL_STEP: begin
					if (mul_rsp.done) begin
						state_q <= ST_DIV_STEP;
					end
				end
				ST_DIV_STEP: begin
					if (div_rsp.done) begin
						state_q <= ST_RAMP;
					end
				end
				ST_RAMP: begin
					state_q <= ST_MODE;
				end
				ST_MODE: begin
					state_q <= need_p ? ST_MUL_GAIN : ST_FIN;
				end
				ST_MUL_GAIN: begin
					if (mul_rsp.done) begin
						state_q <= ST_MUL_TIME;
					end
				end
				ST_MUL_TIME: begin
					if (mul_rsp.done) begin
						state_q <= ST_DIV_PROP;
					end
				end
				ST_DIV_PROP: begin
					if (div_rsp.done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// kept ramp and brake state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_q  <= '0;
			brake_q <= '0;
		end else begin
			if (state_q == ST_RAMP) begin
				ramp_q <= ramp_nxt;
			end
			if (out_load) begin
				brake_q <= brk_nxt;
			end
		end
	end

	// tick fields and mode
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		if (state_q == ST_MODE) begin
			mode_q <= mode_nxt;
			neg_q  <= berr[SpW];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_q.throttle_level <= thr_nxt;
			rsp_q.brake_level    <= brk_nxt;
			rsp_q.ramped_speed   <= ramp_q;
			rsp_q.drive_mode     <= mode_q;
		end
	end

	// the two units are never started together
	a_one_start: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_req.start && div_req.start))
		else $error("multiplier and divider started in the same cycle");

	// both units are quiet whenever a new tick may enter
	a_units_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> (!mul_rsp.busy && !div_rsp.busy))
		else $error("arithmetic unit busy while idle");

	// an accepted tick starts the step multiply
	a_accept_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> mul_rsp.busy)
		else $error("accepted tick did not start the multiplier");

	// loaded brake never exceeds its clip and throttle is never negative
	a_out_clip: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (($signed(brk_nxt) <= $signed({1'b0, max_brake_q})) && !thr_nxt[SpW-1]))
		else $error("result outside its clip");

endmodule
